// ===== rtl/dual_stack_shared_memory_assert.svh =====
// ----------------------------------------------------------------------------
// dual_stack_shared_memory_assert.svh
// Assertion macros for the dual stack block; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef DUAL_STACK_SHARED_MEMORY_ASSERT_SVH
`define DUAL_STACK_SHARED_MEMORY_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, quiet in reset
`define DSSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define DSSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DSSM_ASSERT_IMP(lbl, ante, cons, msg)
`define DSSM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/dssm_pkg.sv =====
// ----------------------------------------------------------------------------
// dssm_pkg
// Constants, codes and shared types of the dual stack block.
// ----------------------------------------------------------------------------
package dssm_pkg;

  localparam int DEPTH       = 32;
  localparam int MAX_RESULTS = 32;
  localparam int WORD_W      = 32;
  localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int LIST_MAX    = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;

  // request codes
  localparam logic [2:0] REQ_PUSH_ONE = 3'd0;
  localparam logic [2:0] REQ_PUSH_TWO = 3'd1;
  localparam logic [2:0] REQ_POP_ONE  = 3'd2;
  localparam logic [2:0] REQ_POP_TWO  = 3'd3;
  localparam logic [2:0] REQ_LIST_ONE = 3'd4;
  localparam logic [2:0] REQ_LIST_TWO = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // pending result, controller to output stage
  typedef struct packed {
    logic                     valid;
    logic [1:0]               status;
    logic signed [WORD_W-1:0] value;
    logic                     last;
  } dssm_res_t;

endpackage

// ===== rtl/dssm_req_if.sv =====
// ----------------------------------------------------------------------------
// dssm_req_if
// Request channel: valid/ready with request code and push word.
// ----------------------------------------------------------------------------
interface dssm_req_if import dssm_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [2:0]               req_type;
  logic signed [WORD_W-1:0] push_value;

  modport source (output valid, req_type, push_value, input ready);
  modport sink   (input valid, req_type, push_value, output ready);
endinterface

// ===== rtl/dssm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dssm_rsp_if
// Result channel: valid/ready with status, word and end-of-run flag.
// ----------------------------------------------------------------------------
interface dssm_rsp_if import dssm_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [WORD_W-1:0] read_value;
  logic                     last_of_run;

  modport source (output valid, status, read_value, last_of_run, input ready);
  modport sink   (input valid, status, read_value, last_of_run, output ready);
endinterface

// ===== rtl/dssm_ram.sv =====
// ----------------------------------------------------------------------------
// dssm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dssm_ram #(
  parameter int WIDTH = 32,
  parameter int WORDS = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/dssm_ctrl.sv =====
// ----------------------------------------------------------------------------
// dssm_ctrl
// Stack pointers, request decode and listing sequencer around the store.
// ----------------------------------------------------------------------------
module dssm_ctrl import dssm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  dssm_req_if.sink            req,
  input  logic                take,
  output dssm_res_t           res,
  output logic                mem_we,
  output logic [ADDR_W-1:0]   mem_waddr,
  output logic [WORD_W-1:0]   mem_wdata,
  output logic                mem_re,
  output logic [ADDR_W-1:0]   mem_raddr,
  input  logic [WORD_W-1:0]   mem_rdata
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  localparam logic [CNT_W-1:0]  DEPTH_C    = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0]  LIST_MAX_C = CNT_W'(LIST_MAX);
  localparam logic [ADDR_W-1:0] TOP_ADDR   = ADDR_W'(DEPTH - 1);

  logic              state, state_next;
  logic [CNT_W-1:0]  low_count, low_count_next;
  logic [CNT_W-1:0]  high_base, high_base_next;
  logic [ADDR_W-1:0] list_addr, list_addr_next;
  logic [CNT_W-1:0]  list_left, list_left_next;
  logic              list_up, list_up_next;
  logic              pend, pend_next;
  logic              pend_mem, pend_mem_next;
  logic [1:0]        pend_status, pend_status_next;
  logic              pend_last, pend_last_next;

  logic              can_issue;
  logic              accept;
  logic              full;
  logic [CNT_W-1:0]  low_m1, high_m1, high_used;

  assign can_issue = !pend || take;
  assign req.ready = (state == S_IDLE) && can_issue;
  assign accept    = req.valid && req.ready;
  assign full      = (low_count >= high_base);
  assign low_m1    = low_count - 1'b1;
  assign high_m1   = high_base - 1'b1;
  assign high_used = DEPTH_C - high_base;

  always_comb begin
    logic [CNT_W-1:0] n_cnt;
    n_cnt            = '0;
    state_next       = state;
    low_count_next   = low_count;
    high_base_next   = high_base;
    list_addr_next   = list_addr;
    list_left_next   = list_left;
    list_up_next     = list_up;
    pend_next        = pend && !take;
    pend_mem_next    = pend_mem;
    pend_status_next = pend_status;
    pend_last_next   = pend_last;
    mem_we           = 1'b0;
    mem_waddr        = '0;
    mem_wdata        = req.push_value;
    mem_re           = 1'b0;
    mem_raddr        = '0;

    if (accept) begin
      case (req.req_type)
        REQ_PUSH_ONE: begin
          pend_next      = 1'b1;
          pend_mem_next  = 1'b0;
          pend_last_next = 1'b1;
          if (full) begin
            pend_status_next = ST_FULL;
          end else begin
            pend_status_next = ST_OK;
            mem_we           = 1'b1;
            mem_waddr        = low_count[ADDR_W-1:0];
            low_count_next   = low_count + 1'b1;
          end
        end
        REQ_PUSH_TWO: begin
          pend_next      = 1'b1;
          pend_mem_next  = 1'b0;
          pend_last_next = 1'b1;
          if (full) begin
            pend_status_next = ST_FULL;
          end else begin
            pend_status_next = ST_OK;
            mem_we           = 1'b1;
            mem_waddr        = high_m1[ADDR_W-1:0];
            high_base_next   = high_m1;
          end
        end
        REQ_POP_ONE: begin
          pend_next      = 1'b1;
          pend_last_next = 1'b1;
          if (low_count == '0) begin
            pend_status_next = ST_EMPTY;
            pend_mem_next    = 1'b0;
          end else begin
            pend_status_next = ST_OK;
            pend_mem_next    = 1'b1;
            mem_re           = 1'b1;
            mem_raddr        = low_m1[ADDR_W-1:0];
            low_count_next   = low_m1;
          end
        end
        REQ_POP_TWO: begin
          pend_next      = 1'b1;
          pend_last_next = 1'b1;
          if (high_base == DEPTH_C) begin
            pend_status_next = ST_EMPTY;
            pend_mem_next    = 1'b0;
          end else begin
            pend_status_next = ST_OK;
            pend_mem_next    = 1'b1;
            mem_re           = 1'b1;
            mem_raddr        = high_base[ADDR_W-1:0];
            high_base_next   = high_base + 1'b1;
          end
        end
        REQ_LIST_ONE: begin
          pend_next = 1'b1;
          if (low_count == '0) begin
            pend_status_next = ST_EMPTY;
            pend_mem_next    = 1'b0;
            pend_last_next   = 1'b1;
          end else begin
            n_cnt            = (low_count > LIST_MAX_C) ? LIST_MAX_C : low_count;
            pend_status_next = ST_OK;
            pend_mem_next    = 1'b1;
            pend_last_next   = (n_cnt == CNT_W'(1));
            mem_re           = 1'b1;
            mem_raddr        = '0;
            list_up_next     = 1'b1;
            list_addr_next   = ADDR_W'(1);
            list_left_next   = n_cnt - 1'b1;
            if (n_cnt != CNT_W'(1)) begin
              state_next = S_LIST;
            end
          end
        end
        REQ_LIST_TWO: begin
          pend_next = 1'b1;
          if (high_base == DEPTH_C) begin
            pend_status_next = ST_EMPTY;
            pend_mem_next    = 1'b0;
            pend_last_next   = 1'b1;
          end else begin
            n_cnt            = (high_used > LIST_MAX_C) ? LIST_MAX_C : high_used;
            pend_status_next = ST_OK;
            pend_mem_next    = 1'b1;
            pend_last_next   = (n_cnt == CNT_W'(1));
            mem_re           = 1'b1;
            mem_raddr        = TOP_ADDR;
            list_up_next     = 1'b0;
            list_addr_next   = TOP_ADDR - 1'b1;
            list_left_next   = n_cnt - 1'b1;
            if (n_cnt != CNT_W'(1)) begin
              state_next = S_LIST;
            end
          end
        end
        default: begin
          // unused codes: taken, no result
        end
      endcase
    end else if (state == S_LIST && can_issue) begin
      pend_next        = 1'b1;
      pend_mem_next    = 1'b1;
      pend_status_next = ST_OK;
      pend_last_next   = (list_left == CNT_W'(1));
      mem_re           = 1'b1;
      mem_raddr        = list_addr;
      list_addr_next   = list_up ? list_addr + 1'b1 : list_addr - 1'b1;
      list_left_next   = list_left - 1'b1;
      if (list_left == CNT_W'(1)) begin
        state_next = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      low_count <= '0;
      high_base <= DEPTH_C;
      pend      <= 1'b0;
    end else begin
      state     <= state_next;
      low_count <= low_count_next;
      high_base <= high_base_next;
      pend      <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    list_addr   <= list_addr_next;
    list_left   <= list_left_next;
    list_up     <= list_up_next;
    pend_mem    <= pend_mem_next;
    pend_status <= pend_status_next;
    pend_last   <= pend_last_next;
  end

  assign res.valid  = pend;
  assign res.status = pend_status;
  assign res.value  = pend_mem ? mem_rdata : '0;
  assign res.last   = pend_last;

endmodule

// ===== rtl/dual_stack_shared_memory.sv =====
// ----------------------------------------------------------------------------
// dual_stack_shared_memory
// Two LIFO stacks sharing one word store, with a registered result channel.
// ----------------------------------------------------------------------------
// Two stacks live in one synchronous RAM of DEPTH words: stack one fills
// upward from entry 0, stack two downward from the top entry. Each request
// pushes, pops or lists one stack. A push when the stacks meet answers full
// and stores nothing; a pop or listing of an empty stack answers empty.
// Rate: pushes, pops and refusals run back to back while the sink takes
// results; a listing then issues one RAM read per cycle, and no new
// request is taken until its last read is issued. The RAM read port sets
// this figure. A result is held in a pending register from the edge that
// takes its request (or issues its read) until the output register is
// free, and the sink takes it from there. Requests 6 and 7 are taken and
// dropped. A push writes at the edge that takes it; the next read can come
// no earlier than the following edge, so no forwarding is needed.
// ----------------------------------------------------------------------------
`include "dual_stack_shared_memory_assert.svh"

module dual_stack_shared_memory import dssm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  dssm_req_if.sink   req,
  dssm_rsp_if.source rsp
);

  dssm_res_t         res;
  logic              take;
  logic              out_free;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  // output register
  logic              out_valid;
  logic [1:0]        out_status;
  logic [WORD_W-1:0] out_value;
  logic              out_last;

  // terms for the checks below
  logic              req_fire;
  logic              res_wait;
  logic [3:0]        res_tag;
  logic              rsp_refusal;

  dssm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .take      (take),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  dssm_ram #(
    .WIDTH (WORD_W),
    .WORDS (DEPTH),
    .AW    (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // register frees as the sink takes it, so the pipe never bubbles
  assign out_free = !out_valid || rsp.ready;
  assign take     = res.valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_status <= res.status;
      out_value  <= res.value;
      out_last   <= res.last;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.read_value  = out_value;
  assign rsp.last_of_run = out_last;

  assign req_fire    = req.valid && req.ready && (req.req_type <= REQ_LIST_TWO);
  assign res_wait    = res.valid && !take;
  assign res_tag     = {res.valid, res.status, res.last};
  assign rsp_refusal = rsp.valid && (rsp.status != ST_OK);

  // every defined request leaves a pending result behind it
  `DSSM_ASSERT_NEXT(a_req_gives_res, req_fire, res.valid, "request left no result")
  // a result not taken is held as it was
  `DSSM_ASSERT_NEXT(a_res_held, res_wait, $stable(res_tag), "pending result lost")
  // refusals end their run and carry no word
  `DSSM_ASSERT_IMP(a_refusal_form, rsp_refusal, out_last && out_value == '0, "malformed refusal")

endmodule

// ===== verif/dual_stack_shared_memory_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_stack_shared_memory_tb
// Self-checking bench for the two-stack shared store.
// ----------------------------------------------------------------------------
// A short stimulus table covers both stacks at their edges first: pops and
// listings of empty stacks, pushes of extreme words, unused request codes and
// pops back down to empty. Random phases follow. They fill towards the
// meeting point, drain to empty or mix every request. A local model of both
// stacks predicts each result no typed row gives. Results are compared in
// order, field by field. Both channels idle in random bursts. The sink holds
// off once for a long stretch; mid-run the source once lets every result drain.
// ----------------------------------------------------------------------------

module dual_stack_shared_memory_tb;
  import dssm_pkg::*;

  // request codes the block takes and drops
  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;

  localparam int RANDOM_REQUESTS = 250;
  localparam int CALM_TAIL       = 50;    // last requests run with no idling
  localparam int LONG_HOLD       = 120;   // sink hold-off, in cycles
  localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no request or result taken
  localparam int SETTLE_CYCLES   = 10;

  typedef enum logic [1:0] {PH_FILL, PH_DRAIN, PH_MIXED} phase_kind_t;

  typedef struct {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] value;
    logic                     last_flag;
  } stack_result_t;

  // one row of the opening table; typed rows carry their own single answer
  typedef struct {
    logic [2:0]               code;
    logic [WORD_W-1:0]        word;
    logic                     typed;
    logic [1:0]               status;
    logic [WORD_W-1:0]        value;
  } stim_row_t;

  logic clk;
  logic rst;

  dssm_req_if req_ch ();
  dssm_rsp_if rsp_ch ();

  dual_stack_shared_memory i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Model of the two stacks: one word store, a fill count for stack one and
  // the lowest entry held by stack two.
  // --------------------------------------------------------------------------
  logic signed [WORD_W-1:0] stack_mem [DEPTH];
  logic [CNT_W-1:0]         low_cnt;
  logic [CNT_W-1:0]         high_base;

  stack_result_t due_results[$];  // answers still owed by the block

  // answer of the request being offered, when the table gives one
  logic                     row_typed;
  logic [1:0]               row_status;
  logic signed [WORD_W-1:0] row_value;

  int  errors;
  int  results_checked;
  int  full_seen;
  int  empty_seen;
  int  code_count [8];
  int  quiet_cycles;

  // channel behaviour, steered from the stimulus thread
  bit  source_gaps;
  bit  sink_stalls;
  bit  long_hold_req;
  bit  long_hold_done;

  function automatic stack_result_t stack_result(logic [1:0] st,
                                                 logic signed [WORD_W-1:0] v,
                                                 logic l);
    stack_result_t r;
    r.status    = st;
    r.value     = v;
    r.last_flag = l;
    return r;
  endfunction

  // Applies one request to the model stacks and returns the answers it owes.
  function automatic void stacks_apply(input logic [2:0] code,
                                       input logic signed [WORD_W-1:0] word,
                                       ref stack_result_t res[$]);
    logic meet;
    int   n;
    meet = (low_cnt >= high_base);
    case (code)
      REQ_PUSH_ONE: begin
        if (meet) begin
          res.push_back(stack_result(ST_FULL, 0, 1'b1));
        end else begin
          stack_mem[low_cnt] = word;
          low_cnt++;
          res.push_back(stack_result(ST_OK, 0, 1'b1));
        end
      end
      REQ_PUSH_TWO: begin
        if (meet) begin
          res.push_back(stack_result(ST_FULL, 0, 1'b1));
        end else begin
          high_base--;
          stack_mem[high_base] = word;
          res.push_back(stack_result(ST_OK, 0, 1'b1));
        end
      end
      REQ_POP_ONE: begin
        if (low_cnt == 0) begin
          res.push_back(stack_result(ST_EMPTY, 0, 1'b1));
        end else begin
          low_cnt--;
          res.push_back(stack_result(ST_OK, stack_mem[low_cnt], 1'b1));
        end
      end
      REQ_POP_TWO: begin
        if (high_base >= DEPTH) begin
          res.push_back(stack_result(ST_EMPTY, 0, 1'b1));
        end else begin
          res.push_back(stack_result(ST_OK, stack_mem[high_base], 1'b1));
          high_base++;
        end
      end
      REQ_LIST_ONE: begin
        if (low_cnt == 0) begin
          res.push_back(stack_result(ST_EMPTY, 0, 1'b1));
        end else begin
          // bottom of stack one first, capped at the longest run
          n = (low_cnt < LIST_MAX) ? int'(low_cnt) : LIST_MAX;
          for (int i = 0; i < n; i++)
            res.push_back(stack_result(ST_OK, stack_mem[i], i + 1 == n));
        end
      end
      REQ_LIST_TWO: begin
        if (high_base >= DEPTH) begin
          res.push_back(stack_result(ST_EMPTY, 0, 1'b1));
        end else begin
          // stack two is listed from the top entry downward
          n = DEPTH - int'(high_base);
          if (n > LIST_MAX) n = LIST_MAX;
          for (int i = 0; i < n; i++)
            res.push_back(stack_result(ST_OK, stack_mem[DEPTH - 1 - i], i + 1 == n));
        end
      end
      default: ;  // spare codes: no answer, no change
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: both handshakes sampled at the rising edge, before any of this
  // edge's nonblocking updates land.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    stack_result_t got;
    stack_result_t want;
    stack_result_t fresh[$];
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status    = rsp_ch.status;
        got.value     = rsp_ch.read_value;
        got.last_flag = rsp_ch.last_of_run;
        if (due_results.size() == 0) begin
          $display("%0t: result with none due: status %0d value %h last %0b",
                   $time, got.status, got.value, got.last_flag);
          errors++;
        end else begin
          want = due_results.pop_front();
          results_checked++;
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.value !== want.value) begin
            $display("%0t: read_value expected %h, got %h", $time, want.value, got.value);
            errors++;
          end
          if (got.last_flag !== want.last_flag) begin
            $display("%0t: last_of_run expected %0b, got %0b", $time, want.last_flag,
                     got.last_flag);
            errors++;
          end
          if (want.status == ST_FULL) full_seen++;
          if (want.status == ST_EMPTY) empty_seen++;
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        fresh.delete();
        code_count[req_ch.req_type]++;
        stacks_apply(req_ch.req_type, req_ch.push_value, fresh);
        // a typed row replaces the model's answer but the model still moves on
        if (row_typed)
          due_results.push_back(stack_result(row_status, row_value, 1'b1));
        else
          foreach (fresh[i]) due_results.push_back(fresh[i]);
      end
    end
  end

  // watchdog: ends the run if neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results still due", $time, due_results.size());
      $display("dual_stack_shared_memory_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: random stall bursts, plus one long hold-off on request so
  // the block backs up and stops taking requests.
  // --------------------------------------------------------------------------
  initial begin
    rsp_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Request source
  // --------------------------------------------------------------------------
  // Offers one request and returns at the edge that takes it; valid stays
  // high so a following request goes out back to back.
  task automatic send_request(input logic [2:0] code, input logic [WORD_W-1:0] word,
                              input logic typed, input logic [1:0] st,
                              input logic [WORD_W-1:0] val);
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= code;
    req_ch.push_value <= word;
    row_typed         <= typed;
    row_status        <= st;
    row_value         <= val;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic source_idle(input int cycles);
    req_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // pause the source until the block owes nothing
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  function automatic logic [2:0] pick_code(phase_kind_t kind);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
    case (kind)
      PH_FILL: begin
        if (roll < 88) return $urandom_range(0, 1) ? REQ_PUSH_ONE : REQ_PUSH_TWO;
        if (roll < 94) return $urandom_range(0, 1) ? REQ_POP_ONE : REQ_POP_TWO;
        return $urandom_range(0, 1) ? REQ_LIST_ONE : REQ_LIST_TWO;
      end
      PH_DRAIN: begin
        if (roll < 82) return $urandom_range(0, 1) ? REQ_POP_ONE : REQ_POP_TWO;
        if (roll < 91) return $urandom_range(0, 1) ? REQ_PUSH_ONE : REQ_PUSH_TWO;
        return $urandom_range(0, 1) ? REQ_LIST_ONE : REQ_LIST_TWO;
      end
      default: return 3'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  stim_row_t directed_rows [22];

  initial begin
    phase_kind_t kind;
    int          phase_len;
    int          sent;
    bit          first_phase;
    bit          drain_done;
    logic [2:0]  code;

    clk = 1'b0;
    rst <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_PUSH_ONE;
    req_ch.push_value <= '0;
    row_typed  <= 1'b0;
    row_status <= ST_OK;
    row_value  <= '0;
    errors = 0;
    results_checked = 0;
    full_seen = 0;
    empty_seen = 0;
    foreach (code_count[i]) code_count[i] = 0;
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    long_hold_req = 1'b0;
    long_hold_done = 1'b0;

    // model after reset: both stacks empty
    low_cnt = '0;
    high_base = CNT_W'(DEPTH);
    foreach (stack_mem[i]) stack_mem[i] = '0;

    directed_rows = '{
      // empty stacks refuse pops and listings
      '{REQ_POP_ONE,  32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
      '{REQ_POP_TWO,  32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
      '{REQ_LIST_ONE, 32'hFFFF_FFFF, 1'b1, ST_EMPTY, 32'h0000_0000},
      '{REQ_LIST_TWO, 32'hFFFF_FFFF, 1'b1, ST_EMPTY, 32'h0000_0000},
      // extreme words onto both stacks
      '{REQ_PUSH_ONE, 32'h7FFF_FFFF, 1'b1, ST_OK,    32'h0000_0000},
      '{REQ_PUSH_ONE, 32'h8000_0000, 1'b1, ST_OK,    32'h0000_0000},
      '{REQ_PUSH_TWO, 32'h0000_0000, 1'b1, ST_OK,    32'h0000_0000},
      '{REQ_PUSH_TWO, 32'hFFFF_FFFF, 1'b1, ST_OK,    32'h0000_0000},
      '{REQ_PUSH_ONE, 32'hAAAA_AAAA, 1'b0, ST_OK,    32'h0000_0000},
      '{REQ_PUSH_TWO, 32'h5555_5555, 1'b0, ST_OK,    32'h0000_0000},
      '{REQ_LIST_ONE, 32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000},
      '{REQ_LIST_TWO, 32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000},
      // spare codes vanish without an answer
      '{REQ_SPARE_A,  32'hDEAD_BEEF, 1'b0, ST_OK,    32'h0000_0000},
      '{REQ_SPARE_B,  32'h1234_5678, 1'b0, ST_OK,    32'h0000_0000},
      // pop back down to empty, newest word first
      '{REQ_POP_ONE,  32'h0000_0000, 1'b1, ST_OK,    32'hAAAA_AAAA},
      '{REQ_POP_TWO,  32'h0000_0000, 1'b1, ST_OK,    32'h5555_5555},
      '{REQ_POP_ONE,  32'h0000_0000, 1'b1, ST_OK,    32'h8000_0000},
      '{REQ_POP_ONE,  32'h0000_0000, 1'b1, ST_OK,    32'h7FFF_FFFF},
      '{REQ_POP_ONE,  32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
      '{REQ_POP_TWO,  32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000},
      '{REQ_POP_TWO,  32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000},
      '{REQ_POP_TWO,  32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if ($urandom_range(0, 3) == 0) source_idle($urandom_range(1, 14));
      send_request(directed_rows[i].code, directed_rows[i].word, directed_rows[i].typed,
                   directed_rows[i].status, directed_rows[i].value);
    end
    wait_drained();

    // Random phases. The first always fills, so the stacks meet early; spare
    // codes are noise and do not count towards the total.
    sent = 0;
    first_phase = 1'b1;
    drain_done = 1'b0;
    while (sent < RANDOM_REQUESTS) begin
      kind = first_phase ? PH_FILL : phase_kind_t'($urandom_range(0, 2));
      phase_len = first_phase ? 45 : $urandom_range(10, 45);
      first_phase = 1'b0;
      for (int k = 0; k < phase_len && sent < RANDOM_REQUESTS; k++) begin
        if (sent >= RANDOM_REQUESTS - CALM_TAIL) begin
          source_gaps = 1'b0;
          sink_stalls = 1'b0;
        end
        // long sink hold-off while requests keep coming
        if (sent >= 100) long_hold_req = 1'b1;
        if (sent >= 180 && !drain_done) begin
          wait_drained();
          drain_done = 1'b1;
        end
        if (source_gaps && $urandom_range(0, 5) == 0) source_idle($urandom_range(1, 14));
        code = pick_code(kind);
        send_request(code, pick_word(), 1'b0, ST_OK, '0);
        if (code <= REQ_LIST_TWO) sent++;
      end
    end
    req_ch.valid <= 1'b0;

    do @(posedge clk); while (due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("requests taken: push %0d/%0d, pop %0d/%0d, list %0d/%0d, spare %0d",
             code_count[REQ_PUSH_ONE], code_count[REQ_PUSH_TWO], code_count[REQ_POP_ONE],
             code_count[REQ_POP_TWO], code_count[REQ_LIST_ONE], code_count[REQ_LIST_TWO],
             code_count[REQ_SPARE_A] + code_count[REQ_SPARE_B]);
    $display("results checked %0d (full refusals %0d, empty refusals %0d), %0d mismatches",
             results_checked, full_seen, empty_seen, errors);
    if (errors == 0) begin
      $display("dual_stack_shared_memory_tb: done, clean");
    end else begin
      $display("dual_stack_shared_memory_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dssm_pkg.sv
rtl/dssm_req_if.sv
rtl/dssm_rsp_if.sv
rtl/dssm_ram.sv
rtl/dssm_ctrl.sv
rtl/dual_stack_shared_memory.sv
verif/dual_stack_shared_memory_tb.sv
